@@ hdl/ppsched_pkg.sv @@
package ppsched_pkg;

  // Defaults for the top-level parameters
  localparam int SLOTS_DEF     = 16;
  localparam int TIME_BITS_DEF = 32;

  // Fixed field widths
  localparam int ID_W       = 8;
  localparam int PRIO_W     = 8;
  localparam int BURST_W    = 16;
  localparam int STATUS_W   = 3;
  localparam int OUT_TIME_W = 32;

  // Stream widths
  localparam int IN_DATA_W  = ID_W + PRIO_W + BURST_W;
  localparam int OUT_DATA_W = ID_W + 5 * OUT_TIME_W;

  // Request kinds carried on s_tuser
  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED   = 3'd0,
    ST_FULL       = 3'd1,
    ST_ZERO_BURST = 3'd2,
    ST_IDLE_TICK  = 3'd3,
    ST_RAN        = 3'd4,
    ST_FINISHED   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_UPD,
    S_EMIT
  } fsm_t;

endpackage

@@ hdl/ppsched_ram.sv @@
module ppsched_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/preemptive_priority_scheduler.sv @@
// Tick-driven preemptive priority scheduler over SLOTS job slots. Each request
// on the slave stream is either an arrival (s_tuser = 0), which stores the job
// in the lowest free slot stamped with the current time, or a tick
// (s_tuser = 1), which runs the ready job with the smallest priority number
// for one time unit (ties: earlier arrival, then lower slot) and advances the
// time counter, wrapping modulo 2^TIME_BITS. Every request yields exactly one
// result on the master stream; its status code sits on m_tuser, and the
// timing figures are non-zero only when a job finishes. Arrivals with a zero
// burst are rejected and not stored, arrivals to a full table are dropped.
// A zero-burst arrival skips the slot scan and goes straight to the update
// and emit states; every other request first runs the slot scan, which
// reads one slot record a cycle from the slot RAM through one shared
// priority/age comparator, then drains the last read, updates and emits.
// A result held back by m_tready holds the sequencer in the emit state.
// s_tready is low while a request is in work; a finished result may wait in
// the output register while the next request is already taken.
module preemptive_priority_scheduler
  import ppsched_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // job_id[7:0], job_priority[15:8], job_burst[31:16]
  input  logic                  s_tuser,   // cmd: 0 arrival, 1 tick
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // run_id[7:0], start_at[39:8], finish_at[71:40],
                                           // response[103:72], turnaround[135:104],
                                           // waiting[167:136]
  output logic [STATUS_W-1:0]   m_tuser    // status
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int EXT_W = (TIME_BITS > OUT_TIME_W) ? TIME_BITS : OUT_TIME_W;

  // One slot record as held in the slot RAM
  typedef struct packed {
    logic [ID_W-1:0]      job;
    logic [PRIO_W-1:0]    prio;
    logic [BURST_W-1:0]   burst;
    logic [BURST_W-1:0]   left;
    logic [TIME_BITS-1:0] arrival;
    logic [TIME_BITS-1:0] start;
  } slot_rec_t;

  fsm_t state, state_next;

  // Request latched at acceptance
  logic               req_cmd;
  logic [ID_W-1:0]    req_id;
  logic [PRIO_W-1:0]  req_prio;
  logic [BURST_W-1:0] req_burst;

  // Per-slot flags in flops, cleared by reset
  logic [SLOTS-1:0] slot_valid;
  logic [SLOTS-1:0] slot_started;

  logic [TIME_BITS-1:0] now;

  // Scan sequencer: address issue and the slot whose data is on the RAM port
  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] chk_idx;
  logic             chk_live;

  // Best candidate so far (free slot for an arrival, ready job for a tick)
  logic                 found;
  logic [IDX_W-1:0]     best_idx;
  logic [ID_W-1:0]      best_job;
  logic [PRIO_W-1:0]    best_prio;
  logic [BURST_W-1:0]   best_burst;
  logic [BURST_W-1:0]   best_left;
  logic [TIME_BITS-1:0] best_arr;
  logic [TIME_BITS-1:0] best_start;
  logic [TIME_BITS-1:0] best_age;

  // Result held between update and emit
  status_t              res_status;
  logic [ID_W-1:0]      res_id;
  logic [TIME_BITS-1:0] res_st;
  logic [TIME_BITS-1:0] res_fin;
  logic [TIME_BITS-1:0] res_resp;
  logic [TIME_BITS-1:0] res_tat;
  logic [BURST_W-1:0]   res_burst;

  // RAM port
  logic         ram_we;
  logic [IDX_W-1:0] ram_waddr;
  slot_rec_t    ram_wdata;
  slot_rec_t    ram_rdata;

  // Shared comparator
  logic [TIME_BITS-1:0] rd_age;
  logic                 rd_better;
  logic                 cand_take;

  // Update-step values
  logic                 upd_first;
  logic [TIME_BITS-1:0] upd_st;
  logic [BURST_W-1:0]   upd_left;
  logic                 upd_done;

  // Output field extension to the fixed 32-bit result fields
  logic [EXT_W-1:0] ext_st, ext_fin, ext_resp, ext_tat, ext_wt;
  logic             out_free;

  ppsched_ram #(
    .WIDTH ($bits(slot_rec_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Shared comparator: judges the slot now on the RAM read port
  // --------------------------------------------------------------------------
  always_comb begin
    rd_age    = now - ram_rdata.arrival;
    rd_better = !found ||
                (ram_rdata.prio < best_prio) ||
                ((ram_rdata.prio == best_prio) && (rd_age > best_age));
    if (req_cmd == CMD_TICK) begin
      cand_take = chk_live && slot_valid[chk_idx] && rd_better;
    end else begin
      // arrival: first free slot in index order
      cand_take = chk_live && !slot_valid[chk_idx] && !found;
    end
  end

  // --------------------------------------------------------------------------
  // Update-step values for the chosen job
  // --------------------------------------------------------------------------
  always_comb begin
    upd_first = !slot_started[best_idx];
    upd_st    = upd_first ? now : best_start;
    upd_left  = best_left - 1'b1;
    upd_done  = (best_left == BURST_W'(1));
  end

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = best_idx;
    ram_wdata  = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == CMD_ARRIVE && s_tdata[IN_DATA_W-1 -: BURST_W] == '0) begin
            state_next = S_UPD;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_idx == IDX_W'(SLOTS - 1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        state_next = S_EMIT;
        if (req_cmd == CMD_ARRIVE) begin
          if (req_burst != '0 && found) begin
            ram_we            = 1'b1;
            ram_wdata.job     = req_id;
            ram_wdata.prio    = req_prio;
            ram_wdata.burst   = req_burst;
            ram_wdata.left    = req_burst;
            ram_wdata.arrival = now;
            ram_wdata.start   = '0;
          end
        end else if (found) begin
          ram_we            = 1'b1;
          ram_wdata.job     = best_job;
          ram_wdata.prio    = best_prio;
          ram_wdata.burst   = best_burst;
          ram_wdata.left    = upd_left;
          ram_wdata.arrival = best_arr;
          ram_wdata.start   = upd_st;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control state: flags, time, scan counter, output valid
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid   <= '0;
      slot_started <= '0;
      now          <= '0;
      scan_idx     <= '0;
      chk_live     <= 1'b0;
      found        <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      chk_live <= (state == S_SCAN);
      if (state == S_IDLE) begin
        scan_idx <= '0;
        found    <= 1'b0;
      end else if (state == S_SCAN && scan_idx != IDX_W'(SLOTS - 1)) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (cand_take) begin
        found <= 1'b1;
      end
      if (state == S_UPD) begin
        if (req_cmd == CMD_ARRIVE) begin
          if (req_burst != '0 && found) begin
            slot_valid[best_idx]   <= 1'b1;
            slot_started[best_idx] <= 1'b0;
          end
        end else begin
          now <= now + 1'b1;
          if (found) begin
            slot_valid[best_idx]   <= !upd_done;
            slot_started[best_idx] <= !upd_done;
          end
        end
      end
      if (state == S_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      req_cmd   <= s_tuser;
      req_id    <= s_tdata[ID_W-1:0];
      req_prio  <= s_tdata[ID_W +: PRIO_W];
      req_burst <= s_tdata[IN_DATA_W-1 -: BURST_W];
    end
    chk_idx <= scan_idx;
    if (cand_take) begin
      best_idx   <= chk_idx;
      best_job   <= ram_rdata.job;
      best_prio  <= ram_rdata.prio;
      best_burst <= ram_rdata.burst;
      best_left  <= ram_rdata.left;
      best_arr   <= ram_rdata.arrival;
      best_start <= ram_rdata.start;
      best_age   <= rd_age;
    end
    if (state == S_UPD) begin
      res_burst <= best_burst;
      res_st    <= upd_st;
      res_fin   <= now + 1'b1;
      res_resp  <= upd_st - best_arr;
      res_tat   <= best_age + 1'b1;
      if (req_cmd == CMD_ARRIVE) begin
        res_id <= req_id;
        if (req_burst == '0) begin
          res_status <= ST_ZERO_BURST;
        end else if (!found) begin
          res_status <= ST_FULL;
        end else begin
          res_status <= ST_ACCEPTED;
        end
      end else if (!found) begin
        res_id     <= '0;
        res_status <= ST_IDLE_TICK;
      end else begin
        res_id     <= best_job;
        res_status <= upd_done ? ST_FINISHED : ST_RAN;
      end
    end
  end

  // Timing figures only for a finished job; waiting formed on the way out
  always_comb begin
    ext_st   = '0;
    ext_fin  = '0;
    ext_resp = '0;
    ext_tat  = '0;
    ext_wt   = '0;
    if (res_status == ST_FINISHED) begin
      ext_st   = EXT_W'(res_st);
      ext_fin  = EXT_W'(res_fin);
      ext_resp = EXT_W'(res_resp);
      ext_tat  = EXT_W'(res_tat);
      ext_wt   = EXT_W'(TIME_BITS'(res_tat - TIME_BITS'(res_burst)));
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      m_tuser <= res_status;
      m_tdata <= {ext_wt[OUT_TIME_W-1:0], ext_tat[OUT_TIME_W-1:0],
                  ext_resp[OUT_TIME_W-1:0], ext_fin[OUT_TIME_W-1:0],
                  ext_st[OUT_TIME_W-1:0], res_id};
    end
  end

endmodule

@@ hdl/ppsched_chk.sv @@
module ppsched_chk
  import ppsched_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [IN_DATA_W-1:0]  s_tdata,
  input logic                  s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [STATUS_W-1:0]   m_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // one request in work at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // timing figures only on completion
  a_times: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_FINISHED |-> m_tdata[OUT_DATA_W-1:ID_W] == '0)
    else $error("timing figures on unfinished result");

  // idle tick names no job
  a_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_IDLE_TICK |-> m_tdata[ID_W-1:0] == '0)
    else $error("idle tick carries a job id");

endmodule

bind preemptive_priority_scheduler ppsched_chk u_chk (.*);
